// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared macros for the concurrent checks in the RTL. Every check samples
// on the rising edge of clk and is held off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge out of reset.
`define SPIM_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// A condition that implies another at the same edge.
`define SPIM_ASSERT_IMPLY(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

`endif

// ===== rtl/core/spim_pkg.sv =====
// ----------------------------------------------------------------------------
// SPI register access master package
// Types, phase codes and sizes shared by the sequencer step logic and the
// top level.
// ----------------------------------------------------------------------------
package spim_pkg;

	// Width of the delay register and the wait counter.
	localparam int DelayWidth = 16;
	localparam logic [DelayWidth-1:0] DelayReset = DelayWidth'(2);

	// Request codes carried on the op field.
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	// Sequencer phase codes.
	localparam logic [2:0] PH_IDLE      = 3'd0;
	localparam logic [2:0] PH_WR_SCKHI  = 3'd1;
	localparam logic [2:0] PH_WR_SCKLO  = 3'd2;
	localparam logic [2:0] PH_RD_MOSIHI = 3'd3;
	localparam logic [2:0] PH_RD_SAMPLE = 3'd4;
	localparam logic [2:0] PH_RD_END    = 3'd5;
	localparam logic [2:0] PH_STOP      = 3'd6;
	localparam logic [2:0] PH_DONE      = 3'd7;

	// Bit counts at which the address byte and the whole frame are done.
	localparam logic [4:0] BitsByte  = 5'd8;
	localparam logic [4:0] BitsFrame = 5'd16;

	// Sequencer state kept between ticks.
	typedef struct packed {
		logic [2:0]            phase;
		logic [4:0]            bit_cnt;
		logic [DelayWidth-1:0] wait_cnt;
		logic [15:0]           tx_shift;
		logic [7:0]            rx_shift;
		logic                  is_read;
		logic                  cs_n;
		logic                  sck;
		logic                  mosi;
	} spim_state_t;

	// Result of one tick.
	typedef struct packed {
		logic       rejected;
		logic       rdata_valid;
		logic [7:0] rdata;
		logic       busy_res;
		logic       mosi;
		logic       sck;
		logic       cs_n;
	} spim_result_t;

endpackage

// ===== rtl/core/spi_register_access_master.sv =====
// A tick passes from the input register to the result register.
// Throughput: one tick per clock while m_tready is high and no delay write is
// offered; an input register and a result register with backpressure let a new
// tick enter while the last result waits. The sequencer state advances as a tick
// leaves the input register. Reset (arst_n low, asynchronous): idle, cs_n high,
// sck and mosi low, delay_ticks 2, both stages empty.
// ----------------------------------------------------------------------------
// SPI register access master
// Tick-driven SPI mode 0 master for one-byte register writes and reads.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spi_register_access_master (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration: delay_ticks
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	// Tick input
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // addr[6:0], wdata[14:7], miso[15]
	input  logic [1:0]  s_tuser,   // op[1:0]
	// Tick result
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // cs_n[0], sck[1], mosi[2], busy_res[3],
	                               // rdata[11:4], rdata_valid[12], rejected[13],
	                               // zero[15:14]
);

	logic [spim_pkg::DelayWidth-1:0] delay_q;
	logic [spim_pkg::DelayWidth-1:0] dlen;

	logic                   v_s1;
	logic [1:0]             op_s1;
	logic [6:0]             addr_s1;
	logic [7:0]             wdata_s1;
	logic                   miso_s1;

	logic                   v_s2;
	spim_pkg::spim_result_t res_s2;

	spim_pkg::spim_state_t  st_q;
	spim_pkg::spim_state_t  st_nxt;
	spim_pkg::spim_result_t res_nxt;

	logic                   adv_s2;
	logic                   st_idle;
	logic                   rd_done_s2;

	// Configuration register, written only while no tick waits in the input register.
	assign cfg_ready = !v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= spim_pkg::DelayReset;
		end else if (cfg_valid && cfg_ready) begin
			delay_q <= cfg_data[spim_pkg::DelayWidth-1:0];
		end
	end

	// A delay of zero acts as one tick.
	assign dlen = (delay_q == '0) ? spim_pkg::DelayWidth'(1) : delay_q;

	// Handshake between the stages. No tick enters while a delay write is offered.
	assign adv_s2   = v_s1 && (!v_s2 || m_tready);
	assign s_tready = (!v_s1 || adv_s2) && !cfg_valid;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!v_s1 || adv_s2) begin
			v_s1 <= s_tvalid && s_tready;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1    <= s_tuser;
			addr_s1  <= s_tdata[6:0];
			wdata_s1 <= s_tdata[14:7];
			miso_s1  <= s_tdata[15];
		end
	end

	// Sequencer step for the tick in the input register.
	spim_step u_step (
		.cur   (st_q),
		.op    (op_s1),
		.addr  (addr_s1),
		.wdata (wdata_s1),
		.miso  (miso_s1),
		.dlen  (dlen),
		.nxt   (st_nxt),
		.res   (res_nxt)
	);

	// Sequencer state, updated as the tick moves on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase    <= spim_pkg::PH_IDLE;
			st_q.bit_cnt  <= '0;
			st_q.wait_cnt <= '0;
			st_q.tx_shift <= '0;
			st_q.rx_shift <= '0;
			st_q.is_read  <= 1'b0;
			st_q.cs_n     <= 1'b1;
			st_q.sck      <= 1'b0;
			st_q.mosi     <= 1'b0;
		end else if (adv_s2) begin
			st_q <= st_nxt;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (!v_s2 || m_tready) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			res_s2 <= res_nxt;
		end
	end

	assign m_tvalid = v_s2;
	assign m_tdata  = {2'b00, res_s2};

	// Checks on the sequencer.
	assign st_idle    = (st_q.phase == spim_pkg::PH_IDLE);
	assign rd_done_s2 = v_s2 && res_s2.rdata_valid;

	`SPIM_ASSERT_IMPLY(a_idle_no_wait, st_idle, st_q.wait_cnt == '0, "idle with a pending wait")
	`SPIM_ASSERT_IMPLY(a_idle_cs_high, st_idle, st_q.cs_n && !st_q.sck, "idle with pins active")
	`SPIM_ASSERT_ALWAYS(a_bit_cnt_range, st_q.bit_cnt <= spim_pkg::BitsFrame, "bit count overrun")
	`SPIM_ASSERT_IMPLY(a_valid_not_busy, rd_done_s2, !res_s2.busy_res && res_s2.cs_n, "busy read")

endmodule

// ===== rtl/core/spim_step.sv =====
// ----------------------------------------------------------------------------
// SPI sequencer step
// Combinational next state and result for one tick of the mode 0 sequencer.
// ----------------------------------------------------------------------------
module spim_step (
	input  spim_pkg::spim_state_t              cur,
	input  logic [1:0]                         op,
	input  logic [6:0]                         addr,
	input  logic [7:0]                         wdata,
	input  logic                               miso,
	input  logic [spim_pkg::DelayWidth-1:0]    dlen,
	output spim_pkg::spim_state_t              nxt,
	output spim_pkg::spim_result_t             res
);

	logic                              request;
	logic                              valid;
	logic                              rejected;
	logic [spim_pkg::DelayWidth-1:0]   wait_dec;
	logic [4:0]                        bit_inc;

	assign request  = (op == spim_pkg::OP_WRITE) || (op == spim_pkg::OP_READ);
	assign wait_dec = cur.wait_cnt - spim_pkg::DelayWidth'(1);
	assign bit_inc  = cur.bit_cnt + 5'd1;

	// Next state of the sequencer for this tick.
	always_comb begin
		nxt      = cur;
		valid    = 1'b0;
		rejected = 1'b0;
		if (cur.phase == spim_pkg::PH_IDLE) begin
			if (request) begin
				nxt.is_read  = (op == spim_pkg::OP_READ);
				nxt.tx_shift = (op == spim_pkg::OP_READ) ? {1'b0, addr, 8'h00}
				                                         : {1'b1, addr, wdata};
				nxt.rx_shift = 8'h00;
				nxt.bit_cnt  = 5'd0;
				nxt.cs_n     = 1'b0;
				nxt.wait_cnt = dlen;
				nxt.phase    = spim_pkg::PH_WR_SCKHI;
			end
		end else begin
			rejected = request;
			if (cur.wait_cnt != '0) begin
				nxt.wait_cnt = wait_dec;
				if ((wait_dec == '0) && (cur.phase == spim_pkg::PH_DONE)) begin
					nxt.phase = spim_pkg::PH_IDLE;
					valid     = cur.is_read;
				end
			end else begin
				case (cur.phase)
					spim_pkg::PH_WR_SCKHI: begin
						nxt.mosi     = cur.tx_shift[15];
						nxt.sck      = 1'b1;
						nxt.wait_cnt = dlen;
						nxt.phase    = spim_pkg::PH_WR_SCKLO;
					end
					spim_pkg::PH_WR_SCKLO: begin
						nxt.sck      = 1'b0;
						nxt.tx_shift = {cur.tx_shift[14:0], 1'b0};
						nxt.bit_cnt  = bit_inc;
						nxt.wait_cnt = dlen;
						if (cur.is_read && (bit_inc == spim_pkg::BitsByte)) begin
							nxt.phase = spim_pkg::PH_RD_MOSIHI;
						end else if (!cur.is_read && (bit_inc == spim_pkg::BitsFrame)) begin
							nxt.phase = spim_pkg::PH_STOP;
						end else begin
							nxt.phase = spim_pkg::PH_WR_SCKHI;
						end
					end
					spim_pkg::PH_RD_MOSIHI: begin
						nxt.mosi     = 1'b1;
						nxt.wait_cnt = dlen;
						nxt.phase    = spim_pkg::PH_RD_SAMPLE;
					end
					spim_pkg::PH_RD_SAMPLE: begin
						nxt.sck      = 1'b1;
						nxt.rx_shift = {cur.rx_shift[6:0], miso};
						nxt.phase    = spim_pkg::PH_RD_END;
					end
					spim_pkg::PH_RD_END: begin
						nxt.sck     = 1'b0;
						nxt.mosi    = 1'b0;
						nxt.bit_cnt = bit_inc;
						nxt.phase   = (bit_inc >= spim_pkg::BitsFrame) ? spim_pkg::PH_STOP
						                                               : spim_pkg::PH_RD_MOSIHI;
					end
					spim_pkg::PH_STOP: begin
						nxt.cs_n     = 1'b1;
						nxt.wait_cnt = dlen;
						nxt.phase    = spim_pkg::PH_DONE;
					end
					default: begin
						// Done with no wait left: finish the transaction.
						valid     = (cur.phase == spim_pkg::PH_DONE) ? cur.is_read : 1'b0;
						nxt.cs_n  = 1'b1;
						nxt.sck   = 1'b0;
						nxt.phase = spim_pkg::PH_IDLE;
					end
				endcase
			end
		end
	end

	// Pin levels and status after the tick.
	always_comb begin
		res.cs_n        = nxt.cs_n;
		res.sck         = nxt.sck;
		res.mosi        = nxt.mosi;
		res.busy_res    = (nxt.phase != spim_pkg::PH_IDLE);
		res.rdata       = valid ? nxt.rx_shift : 8'h00;
		res.rdata_valid = valid;
		res.rejected    = rejected;
	end

endmodule
